>>> src/sitc_pkg.sv
// Shared types, constants and helpers for the sorted id table reference checker.
// Used by the RTL modules of the block, apart from sitc_ram, and by its checker; depends on nothing.
`default_nettype none

package sitc_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 1024;
   localparam int NUM_TABLES  = 3;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

   // Field widths
   localparam int OP_W     = 2;
   localparam int KIND_W   = 2;
   localparam int ID_W     = 64;
   localparam int POS_W    = 10;
   localparam int STATUS_W = 2;

   localparam logic [POS_W-1:0] POS_MAX = 10'd1023;

   // Opcodes
   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

   // Kind that addresses no table
   localparam logic [KIND_W-1:0] KIND_BAD = 2'd3;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_ASC  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_KIND = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic latch;    // capture the accepted item, set up the search window
      logic search;   // search state: fold in read data on step, issue next probe
      logic step;     // read data for the last probe is present this cycle
      logic load_rd;  // read the last stored id of the addressed table
      logic load_wr;  // judge the load and append on success
      logic finish;   // move the result into the output register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic more;     // search window still open after this cycle
   } sts_type;

   // Saturate a table position to the output field
   function automatic logic [POS_W-1:0] clip_pos(input logic [COUNT_W-1:0] p);
      logic [31:0] wide;
      wide = 32'(p);
      if (wide > 32'(POS_MAX)) return POS_MAX;
      return wide[POS_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> src/sorted_id_table_reference_checker.sv
// A load reads the last stored id, then judges and appends; a clear goes
// straight to the result; lookup and check run a lower-bound search of at
// most ceil(log2(count + 1)) probes. One item at a time: the next item can be
// accepted in the same cycle as its result goes valid, and a stalled result
// delays the next hand-off.
// Synchronous reset empties all tables and rearms the first-missing latch.
`default_nettype none

module sorted_id_table_reference_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [sitc_pkg::OP_W-1:0]       req_opcode,
   input  logic [sitc_pkg::KIND_W-1:0]     req_target_kind,
   input  logic [sitc_pkg::ID_W-1:0]       req_target_id,
   input  logic [sitc_pkg::KIND_W-1:0]     req_owner_kind,
   input  logic [sitc_pkg::ID_W-1:0]       req_owner_id,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_found,
   output logic [sitc_pkg::POS_W-1:0]      rsp_position,
   output logic                            rsp_first_missing,
   output logic [sitc_pkg::KIND_W-1:0]     rsp_report_owner_kind,
   output logic [sitc_pkg::ID_W-1:0]       rsp_report_owner_id,
   output logic [sitc_pkg::KIND_W-1:0]     rsp_report_kind,
   output logic [sitc_pkg::ID_W-1:0]       rsp_report_id,
   output logic [sitc_pkg::STATUS_W-1:0]   rsp_status
);
   import sitc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer
   sitc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .sts        (sts)
   );

   // Tables, search and result register
   sitc_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .req_opcode            (req_opcode),
      .req_target_kind       (req_target_kind),
      .req_target_id         (req_target_id),
      .req_owner_kind        (req_owner_kind),
      .req_owner_id          (req_owner_id),
      .rsp_found             (rsp_found),
      .rsp_position          (rsp_position),
      .rsp_first_missing     (rsp_first_missing),
      .rsp_report_owner_kind (rsp_report_owner_kind),
      .rsp_report_owner_id   (rsp_report_owner_id),
      .rsp_report_kind       (rsp_report_kind),
      .rsp_report_id         (rsp_report_id),
      .rsp_status            (rsp_status)
   );

endmodule

`default_nettype wire

>>> src/sitc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`default_nettype none

module sitc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> src/sitc_datapath.sv
// Datapath: item registers, three id tables, counts, binary search window,
// load judgement and the output register. Uses sitc_pkg and sitc_ram.
`default_nettype none

module sitc_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  sitc_pkg::cmd_type               cmd,
   output sitc_pkg::sts_type               sts,
   input  logic [sitc_pkg::OP_W-1:0]       req_opcode,
   input  logic [sitc_pkg::KIND_W-1:0]     req_target_kind,
   input  logic [sitc_pkg::ID_W-1:0]       req_target_id,
   input  logic [sitc_pkg::KIND_W-1:0]     req_owner_kind,
   input  logic [sitc_pkg::ID_W-1:0]       req_owner_id,
   output logic                            rsp_found,
   output logic [sitc_pkg::POS_W-1:0]      rsp_position,
   output logic                            rsp_first_missing,
   output logic [sitc_pkg::KIND_W-1:0]     rsp_report_owner_kind,
   output logic [sitc_pkg::ID_W-1:0]       rsp_report_owner_id,
   output logic [sitc_pkg::KIND_W-1:0]     rsp_report_kind,
   output logic [sitc_pkg::ID_W-1:0]       rsp_report_id,
   output logic [sitc_pkg::STATUS_W-1:0]   rsp_status
);
   import sitc_pkg::*;

   // Item registers
   logic [OP_W-1:0]     op_ff;
   logic [KIND_W-1:0]   kind_ff;
   logic [ID_W-1:0]     id_ff;
   logic [KIND_W-1:0]   okind_ff;
   logic [ID_W-1:0]     oid_ff;

   // Search window and load result
   logic [COUNT_W-1:0]  lo_ff, lo_in;
   logic [COUNT_W-1:0]  hi_ff, hi_in;
   logic [ADDR_W-1:0]   mid_ff, mid_in;
   logic                hit_ff, hit_in;
   logic [STATUS_W-1:0] load_st_ff, load_st_in;

   // Table state
   logic [COUNT_W-1:0]  count_ff [NUM_TABLES];
   logic                missing_ff;

   logic [ID_W-1:0]     rd_data [NUM_TABLES];
   logic [ID_W-1:0]     sel_rd;
   logic [COUNT_W-1:0]  sel_count;
   logic [COUNT_W-1:0]  req_count;
   logic [COUNT_W-1:0]  cnt_m1;
   logic [COUNT_W:0]    mid_sum;
   logic [ADDR_W-1:0]   rd_addr;
   logic                rd_lt;
   logic                is_bad;
   logic                wr_en;

   // Result values
   logic                res_found;
   logic [POS_W-1:0]    res_pos;
   logic                res_first;
   logic [KIND_W-1:0]   res_okind;
   logic [ID_W-1:0]     res_oid;
   logic [KIND_W-1:0]   res_kind;
   logic [ID_W-1:0]     res_id;
   logic [STATUS_W-1:0] res_status;

   // Select read data and count of the latched kind
   always_comb begin
      sel_rd    = '0;
      sel_count = '0;
      unique case (kind_ff)
         2'd0:    begin sel_rd = rd_data[0]; sel_count = count_ff[0]; end
         2'd1:    begin sel_rd = rd_data[1]; sel_count = count_ff[1]; end
         2'd2:    begin sel_rd = rd_data[2]; sel_count = count_ff[2]; end
         default: begin sel_rd = '0;         sel_count = '0;          end
      endcase
   end

   // Count of the kind on the request port, for the search window
   always_comb begin
      unique case (req_target_kind)
         2'd0:    req_count = count_ff[0];
         2'd1:    req_count = count_ff[1];
         2'd2:    req_count = count_ff[2];
         default: req_count = '0;
      endcase
   end

   assign is_bad = (kind_ff == KIND_BAD);

   // Lower-bound step: fold the probe result into the window, pick next probe
   always_comb begin
      rd_lt  = (sel_rd < id_ff);
      lo_in  = lo_ff;
      hi_in  = hi_ff;
      hit_in = hit_ff;
      if (cmd.step) begin
         if (rd_lt) begin
            lo_in = COUNT_W'(mid_ff) + COUNT_W'(1);
         end else begin
            hi_in  = COUNT_W'(mid_ff);
            hit_in = (sel_rd == id_ff);
         end
      end
      mid_sum  = {1'b0, lo_in} + {1'b0, hi_in};
      mid_in   = mid_sum[ADDR_W:1];
      sts.more = (lo_in < hi_in);
   end

   // Load judgement: bad kind, then full, then not ascending
   always_comb begin
      cnt_m1 = sel_count - COUNT_W'(1);
      if (is_bad) begin
         load_st_in = ST_BAD_KIND;
      end else if (sel_count >= COUNT_W'(TABLE_DEPTH)) begin
         load_st_in = ST_FULL;
      end else if (sel_count != '0 && id_ff <= sel_rd) begin
         load_st_in = ST_NOT_ASC;
      end else begin
         load_st_in = ST_OK;
      end
      wr_en = cmd.load_wr && (load_st_in == ST_OK);
   end

   assign rd_addr = cmd.load_rd ? cnt_m1[ADDR_W-1:0] : mid_in;

   // One table memory per kind
   for (genvar g = 0; g < NUM_TABLES; g++) begin : g_table
      sitc_ram #(
         .WIDTH (ID_W),
         .DEPTH (TABLE_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en && (kind_ff == KIND_W'(g))),
         .wr_addr (sel_count[ADDR_W-1:0]),
         .wr_data (id_ff),
         .rd_addr (rd_addr),
         .rd_data (rd_data[g])
      );
   end

   // Item capture and search window
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff    <= req_opcode;
         kind_ff  <= req_target_kind;
         id_ff    <= req_target_id;
         okind_ff <= req_owner_kind;
         oid_ff   <= req_owner_id;
         lo_ff    <= '0;
         hi_ff    <= req_count;
         hit_ff   <= 1'b0;
      end else if (cmd.search) begin
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         hit_ff <= hit_in;
         mid_ff <= mid_in;
      end else if (cmd.load_wr) begin
         lo_ff      <= is_bad ? '0 : sel_count;
         load_st_ff <= load_st_in;
      end
   end

   // Counts and first-missing latch
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TABLES; i++) count_ff[i] <= '0;
         missing_ff <= 1'b0;
      end else if (cmd.finish && op_ff == OP_CLEAR) begin
         for (int i = 0; i < NUM_TABLES; i++) count_ff[i] <= '0;
         missing_ff <= 1'b0;
      end else begin
         for (int i = 0; i < NUM_TABLES; i++) begin
            if (wr_en && kind_ff == KIND_W'(i)) begin
               count_ff[i] <= count_ff[i] + COUNT_W'(1);
            end
         end
         if (cmd.finish && res_first) begin
            missing_ff <= 1'b1;
         end
      end
   end

   // Result fields by opcode
   always_comb begin
      res_found  = 1'b0;
      res_pos    = '0;
      res_first  = 1'b0;
      res_okind  = '0;
      res_oid    = '0;
      res_kind   = kind_ff;
      res_id     = id_ff;
      res_status = ST_OK;
      unique case (op_ff)
         OP_LOAD: begin
            res_pos    = clip_pos(lo_ff);
            res_status = load_st_ff;
         end
         OP_LOOKUP: begin
            res_found  = hit_ff;
            res_pos    = clip_pos(lo_ff);
            res_status = is_bad ? ST_BAD_KIND : ST_OK;
         end
         OP_CHECK: begin
            res_found  = hit_ff;
            res_pos    = clip_pos(lo_ff);
            res_status = is_bad ? ST_BAD_KIND : ST_OK;
            res_okind  = okind_ff;
            res_oid    = oid_ff;
            res_first  = !hit_ff && !missing_ff;
         end
         OP_CLEAR: begin
            res_kind = '0;
            res_id   = '0;
         end
      endcase
   end

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_found             <= res_found;
         rsp_position          <= res_pos;
         rsp_first_missing     <= res_first;
         rsp_report_owner_kind <= res_okind;
         rsp_report_owner_id   <= res_oid;
         rsp_report_kind       <= res_kind;
         rsp_report_id         <= res_id;
         rsp_status            <= res_status;
      end
   end

endmodule

`default_nettype wire

>>> src/sitc_ctrl.sv
// Controller: sequences accept, search, load and result hand-off for one item.
// Uses sitc_pkg for opcodes and the command and status structs.
`default_nettype none

module sitc_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [sitc_pkg::OP_W-1:0]  req_opcode,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output sitc_pkg::cmd_type          cmd,
   input  sitc_pkg::sts_type          sts
);
   import sitc_pkg::*;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SEARCH  = 3'd1;
   localparam logic [2:0] S_LOAD_RD = 3'd2;
   localparam logic [2:0] S_LOAD_WR = 3'd3;
   localparam logic [2:0] S_DONE    = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       pend_ff, pend_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               pend_in   = 1'b0;
               unique case (req_opcode)
                  OP_LOAD:   state_in = S_LOAD_RD;
                  OP_LOOKUP: state_in = S_SEARCH;
                  OP_CHECK:  state_in = S_SEARCH;
                  OP_CLEAR:  state_in = S_DONE;
               endcase
            end
         end
         S_SEARCH: begin
            cmd.search = 1'b1;
            cmd.step   = pend_ff;
            pend_in    = sts.more;
            if (!sts.more) state_in = S_DONE;
         end
         S_LOAD_RD: begin
            cmd.load_rd = 1'b1;
            state_in    = S_LOAD_WR;
         end
         S_LOAD_WR: begin
            cmd.load_wr = 1'b1;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Output valid: set on hand-off, cleared when taken
   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> src/sitc_checker.sv
// Port-level assertions for the sorted id table reference checker, bound
// to the top level. Uses sitc_pkg for status codes and widths.
`default_nettype none

module sitc_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [sitc_pkg::OP_W-1:0]       req_opcode,
   input  logic [sitc_pkg::KIND_W-1:0]     req_target_kind,
   input  logic [sitc_pkg::ID_W-1:0]       req_target_id,
   input  logic [sitc_pkg::KIND_W-1:0]     req_owner_kind,
   input  logic [sitc_pkg::ID_W-1:0]       req_owner_id,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic                            rsp_found,
   input  logic [sitc_pkg::POS_W-1:0]      rsp_position,
   input  logic                            rsp_first_missing,
   input  logic [sitc_pkg::KIND_W-1:0]     rsp_report_owner_kind,
   input  logic [sitc_pkg::ID_W-1:0]       rsp_report_owner_id,
   input  logic [sitc_pkg::KIND_W-1:0]     rsp_report_kind,
   input  logic [sitc_pkg::ID_W-1:0]       rsp_report_id,
   input  logic [sitc_pkg::STATUS_W-1:0]   rsp_status
);
   import sitc_pkg::*;

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_report_id))
      else $error("stalled result dropped or changed");

   // A hit is never reported together with an error status
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == ST_OK)
      else $error("found with non-ok status");

   // A first-missing flag only comes with a miss
   a_first_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_first_missing |-> !rsp_found)
      else $error("first missing on a hit");

   // A bad kind gives no hit and position zero
   a_bad_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_BAD_KIND |-> !rsp_found && rsp_position == '0)
      else $error("bad kind result not empty");

endmodule

bind sorted_id_table_reference_checker sitc_checker u_sitc_checker (.*);

`default_nettype wire
